/* rtl/assert_macros.svh */
// Assertion macros used by the checker module of this block.
// Each macro takes a label, the clock, the active-low reset, the property
// body (or an antecedent and a consequent) and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define HRP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked at the same edge.
`define HRP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked at the next edge.
`define HRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hrp_pkg.sv */
`default_nettype none

package hrp_pkg;

    // Characters that end fields.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Saturation value of the header line counter.
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Parser phases, one-hot.
    typedef enum logic [6:0] {
        PH_METHOD  = 7'b0000001,
        PH_URL     = 7'b0000010,
        PH_VERSION = 7'b0000100,
        PH_SKIP    = 7'b0001000,
        PH_HEADER  = 7'b0010000,
        PH_FINAL   = 7'b0100000,
        PH_ERROR   = 7'b1000000
    } phase_t;

    // Byte classification tags.
    typedef enum logic [2:0] {
        TAG_METHOD  = 3'd0,
        TAG_URL     = 3'd1,
        TAG_VERSION = 3'd2,
        TAG_HEADER  = 3'd3,
        TAG_DELIM   = 3'd4,
        TAG_IGNORED = 3'd5
    } tag_t;

    // Request verdict codes.
    typedef enum logic [1:0] {
        VERDICT_PENDING = 2'd0,
        VERDICT_ACCEPT  = 2'd1,
        VERDICT_REJECT  = 2'd2
    } verdict_t;

    // One input byte with its end-of-message flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // One classified byte.
    typedef struct packed {
        tag_t       field_tag;
        logic [7:0] header_index;
        verdict_t   verdict;
    } result_t;

endpackage

`default_nettype wire

/* rtl/hrp_input_stage.sv */
`default_nettype none

module hrp_input_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hrp_pkg::item_t in_item,
    input  wire logic           advance,
    output logic                stage_valid,
    output hrp_pkg::item_t      stage_item
);
    import hrp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register takes a new byte when empty or when its byte moves on.
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

`default_nettype wire

/* rtl/hrp_parse_core.sv */
`default_nettype none

module hrp_parse_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire hrp_pkg::item_t item,
    output hrp_pkg::result_t    result
);
    import hrp_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic       nonempty_reg;
    logic       nonempty_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    tag_t       tag;
    logic       accept;

    // Classify the byte and work out the next parser state.
    always_comb
    begin
        phase_next    = phase_reg;
        nonempty_next = nonempty_reg;
        count_next    = count_reg;
        tag           = TAG_IGNORED;
        accept        = 1'b0;

        case (phase_reg)
            PH_METHOD, PH_URL:
            begin
                if (item.data_byte == CH_SPACE)
                begin
                    tag = TAG_DELIM;
                    if (nonempty_reg)
                    begin
                        phase_next    = (phase_reg == PH_METHOD) ? PH_URL : PH_VERSION;
                        nonempty_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                else
                begin
                    tag           = (phase_reg == PH_METHOD) ? TAG_METHOD : TAG_URL;
                    nonempty_next = 1'b1;
                end
            end
            PH_VERSION:
            begin
                if (item.data_byte == CH_CR)
                begin
                    tag           = TAG_DELIM;
                    phase_next    = nonempty_reg ? PH_SKIP : PH_ERROR;
                    nonempty_next = 1'b0;
                end
                else
                begin
                    tag           = TAG_VERSION;
                    nonempty_next = 1'b1;
                end
            end
            PH_SKIP:
            begin
                // The byte after a carriage return is passed over unchecked.
                tag           = TAG_DELIM;
                phase_next    = PH_HEADER;
                nonempty_next = 1'b0;
            end
            PH_HEADER:
            begin
                if (item.data_byte == CH_CR)
                begin
                    tag = TAG_DELIM;
                    if (nonempty_reg)
                    begin
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 8'd1;
                        end
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        // An empty line closes the header.
                        phase_next = PH_FINAL;
                    end
                    nonempty_next = 1'b0;
                end
                else
                begin
                    tag           = TAG_HEADER;
                    nonempty_next = 1'b1;
                end
            end
            PH_FINAL:
            begin
                tag = TAG_DELIM;
                if (item.last_byte && (item.data_byte == CH_LF))
                begin
                    accept = 1'b1;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            default:
            begin
                tag        = TAG_IGNORED;
                phase_next = PH_ERROR;
            end
        endcase

        result.field_tag    = tag;
        result.header_index = count_next;
        result.verdict      = VERDICT_PENDING;

        // The final byte gives the verdict and restarts the parser.
        if (item.last_byte)
        begin
            result.verdict = accept ? VERDICT_ACCEPT : VERDICT_REJECT;
            phase_next     = PH_METHOD;
            nonempty_next  = 1'b0;
            count_next     = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_METHOD;
            nonempty_reg <= 1'b0;
            count_reg    <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            nonempty_reg <= nonempty_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/hrp_output_stage.sv */
`default_nettype none

module hrp_output_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire hrp_pkg::result_t result,
    output logic                  out_space,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output hrp_pkg::result_t      out_result
);
    import hrp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Room for a new result when empty or when the held one is taken now.
    assign out_space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_space)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

/* rtl/http_request_header_parser.sv */
// HTTP request header parser.
// Input channel: in_valid/in_ready with data_byte and last_byte; one byte
// of the request per transfer, last_byte high on the final byte.
// Output channel: out_valid/out_ready with field_tag, header_index and
// verdict; exactly one result transfer for every input transfer, in order.
// An input transfer is held in the input register; the byte is then
// classified and the parser state is updated as it moves into the
// result register, from which the earliest result transfer is made.
// Throughput is one byte per cycle while the receiver does not stall,
// as the phase, field and header count registers update for every byte.
// When the receiver stalls, the result register holds its transfer and
// the input register can still take one more byte; in_ready falls once
// both are full.
// Reset clears both valid flags and puts the parser in the method phase
// with a zero header count. The parser also restarts after every final
// byte, whose result carries the accept or reject verdict.
`default_nettype none

module http_request_header_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      field_tag,
    output logic [7:0]      header_index,
    output logic [1:0]      verdict
);
    import hrp_pkg::*;

    item_t   in_item;
    item_t   stage_item;
    logic    stage_valid;
    logic    out_space;
    logic    advance;
    result_t core_result;
    result_t out_result;

    assign in_item.data_byte = data_byte;
    assign in_item.last_byte = last_byte;

    // A byte moves on when it is held and the result register has room.
    assign advance = stage_valid && out_space;

    hrp_input_stage u_input_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    hrp_parse_core u_parse_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_item),
        .result  (core_result)
    );

    hrp_output_stage u_output_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (core_result),
        .out_space  (out_space),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign field_tag    = out_result.field_tag;
    assign header_index = out_result.header_index;
    assign verdict      = out_result.verdict;

endmodule

`default_nettype wire

/* rtl/hrp_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module hrp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] field_tag,
    input wire logic [7:0] header_index,
    input wire logic [1:0] verdict
);
    import hrp_pkg::*;

    logic       out_xfer;
    logic       in_msg_reg;
    logic       in_msg_next;
    logic [7:0] prev_idx_reg;
    logic [7:0] prev_idx_next;

    assign out_xfer = out_valid && out_ready;

    // Track whether the next result belongs to a message already under way.
    always_comb
    begin
        in_msg_next   = in_msg_reg;
        prev_idx_next = prev_idx_reg;
        if (out_xfer)
        begin
            in_msg_next   = (verdict == VERDICT_PENDING);
            prev_idx_next = header_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg   <= 1'b0;
            prev_idx_reg <= 8'd0;
        end
        else
        begin
            in_msg_reg   <= in_msg_next;
            prev_idx_reg <= prev_idx_next;
        end
    end

    `HRP_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(field_tag) && $stable(header_index) && $stable(verdict),
        "Stalled result changed or was withdrawn.")
    `HRP_ASSERT_SAME(a_accept_on_delim, clk, rst_n, out_valid && (verdict == VERDICT_ACCEPT),
        field_tag == TAG_DELIM,
        "Accepted request did not end on a delimiter byte.")
    `HRP_ASSERT_SAME(a_first_index_zero, clk, rst_n, out_valid && !in_msg_reg,
        header_index == 8'd0,
        "First byte of a message shows a nonzero header index.")
    `HRP_ASSERT_SAME(a_index_monotonic, clk, rst_n, out_valid && in_msg_reg,
        (header_index == prev_idx_reg) || (header_index == prev_idx_reg + 8'd1),
        "Header index moved by other than zero or one within a message.")

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import hrp_pkg::*;

    // Length of the random part, in bytes of ordinary requests.
    localparam int RANDOM_BYTES = 500;
    // Header lines in the request that drives the line count into saturation.
    localparam int SATURATING_LINES = 257;
    // Cycles allowed for the pipeline to drain at the end.
    localparam int DRAIN_CYCLES = 8;
    // Hard stop for a hung run.
    localparam int RUN_LIMIT_NS = 2_000_000;

    // Marks whether a directed row carries its own expected result.
    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef enum int
    {
        IDLE_SLOW_SINK,
        IDLE_SLOW_SOURCE,
        IDLE_NONE
    } idle_mode_t;

    // One directed byte with its expected result, where that is typed in.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       typed;
        tag_t       field_tag;
        logic [7:0] header_index;
        verdict_t   verdict;
    } directed_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] field_tag;
    logic [7:0] header_index;
    logic [1:0] verdict;

    // Shadow of the parser state.
    phase_t     parser_phase = PH_METHOD;
    logic       field_seen = 1'b0;
    logic [7:0] line_count = 8'h00;

    // Results owed by the block, oldest first.
    result_t    classified_due [$];
    // Bytes of the request currently being built.
    item_t      request_q [$];
    int         url_pos;
    int         ver_pos;

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         fault_count = 0;

    // Directed bytes: a full request, an empty method, a final byte in the
    // method phase, and a line feed after the empty line that is not final.
    directed_row_t directed_rows [0:25] = '{
        '{"G",      1'b0, TYPED,     TAG_METHOD,  8'd0, VERDICT_PENDING},
        '{CH_SPACE, 1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{"/",      1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{CH_SPACE, 1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{"1",      1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{CH_CR,    1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{8'hFF,    1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{"H",      1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{CH_CR,    1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{8'h00,    1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{CH_CR,    1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{CH_LF,    1'b1, TYPED,     TAG_DELIM,   8'd1, VERDICT_ACCEPT},
        '{CH_SPACE, 1'b0, TYPED,     TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{"x",      1'b0, TYPED,     TAG_IGNORED, 8'd0, VERDICT_PENDING},
        '{8'hFF,    1'b1, TYPED,     TAG_IGNORED, 8'd0, VERDICT_REJECT},
        '{"a",      1'b1, TYPED,     TAG_METHOD,  8'd0, VERDICT_REJECT},
        '{"P",      1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{CH_SPACE, 1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{8'h80,    1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{CH_SPACE, 1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{8'h7F,    1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{CH_CR,    1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{CH_LF,    1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{CH_CR,    1'b0, PREDICTED, TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{CH_LF,    1'b0, TYPED,     TAG_DELIM,   8'd0, VERDICT_PENDING},
        '{"z",      1'b1, TYPED,     TAG_IGNORED, 8'd0, VERDICT_REJECT}
    };

    http_request_header_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .field_tag    (field_tag),
        .header_index (header_index),
        .verdict      (verdict)
    );

    // Free-running clock, 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Classify one byte and advance the shadow parser state.
    function automatic result_t classify_byte(input logic [7:0] b, input logic last);
        result_t r;
        logic    accepted;
        accepted = 1'b0;
        r.field_tag = TAG_IGNORED;
        case (parser_phase)
            PH_METHOD, PH_URL:
            begin
                if (b == CH_SPACE)
                begin
                    r.field_tag = TAG_DELIM;
                    if (field_seen)
                    begin
                        parser_phase = (parser_phase == PH_METHOD) ? PH_URL : PH_VERSION;
                        field_seen = 1'b0;
                    end
                    else
                    begin
                        parser_phase = PH_ERROR;
                    end
                end
                else
                begin
                    r.field_tag = (parser_phase == PH_METHOD) ? TAG_METHOD : TAG_URL;
                    field_seen = 1'b1;
                end
            end
            PH_VERSION:
            begin
                if (b == CH_CR)
                begin
                    r.field_tag = TAG_DELIM;
                    parser_phase = field_seen ? PH_SKIP : PH_ERROR;
                    field_seen = 1'b0;
                end
                else
                begin
                    r.field_tag = TAG_VERSION;
                    field_seen = 1'b1;
                end
            end
            PH_SKIP:
            begin
                r.field_tag = TAG_DELIM;
                parser_phase = PH_HEADER;
                field_seen = 1'b0;
            end
            PH_HEADER:
            begin
                if (b == CH_CR)
                begin
                    r.field_tag = TAG_DELIM;
                    if (field_seen)
                    begin
                        if (line_count != COUNT_MAX)
                            line_count = line_count + 8'd1;
                        parser_phase = PH_SKIP;
                    end
                    else
                    begin
                        parser_phase = PH_FINAL;
                    end
                    field_seen = 1'b0;
                end
                else
                begin
                    r.field_tag = TAG_HEADER;
                    field_seen = 1'b1;
                end
            end
            PH_FINAL:
            begin
                r.field_tag = TAG_DELIM;
                if (last && b == CH_LF)
                    accepted = 1'b1;
                else
                    parser_phase = PH_ERROR;
            end
            default:
            begin
                r.field_tag = TAG_IGNORED;
                parser_phase = PH_ERROR;
            end
        endcase

        r.header_index = line_count;
        r.verdict = VERDICT_PENDING;
        if (last)
        begin
            r.verdict = accepted ? VERDICT_ACCEPT : VERDICT_REJECT;
            parser_phase = PH_METHOD;
            field_seen = 1'b0;
            line_count = 8'h00;
        end
        return r;
    endfunction

    // Any byte other than the one that would end the field.
    function automatic logic [7:0] random_other(input logic [7:0] avoid);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == avoid)
            v = ~v;
        return v;
    endfunction

    function automatic logic [7:0] random_delimiter();
        case ($urandom_range(0, 2))
            0: return CH_SPACE;
            1: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        request_q.insert(request_q.size(), {b, last});
    endtask

    // A field of random content followed by its ending byte.
    task automatic add_field(input int len, input logic [7:0] stop);
        repeat (len)
            push_byte(random_other(stop), 1'b0);
        push_byte(stop, 1'b0);
    endtask

    // A complete, valid request with the given number of header lines.
    task automatic build_wellformed(input int lines, input int max_len);
        request_q.delete();
        add_field($urandom_range(1, 6), CH_SPACE);
        url_pos = request_q.size();
        add_field($urandom_range(1, 10), CH_SPACE);
        ver_pos = request_q.size();
        add_field($urandom_range(1, 8), CH_CR);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        repeat (lines)
        begin
            add_field($urandom_range(1, max_len), CH_CR);
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b1);
    endtask

    // A valid request spoilt in one place.
    task automatic build_broken();
        int k;
        build_wellformed($urandom_range(0, 4), 12);
        k = $urandom_range(0, request_q.size() - 2);
        case ($urandom_range(0, 4))
            0:
            begin
                // Message ends early, in whatever phase the cut falls.
                request_q[k].last_byte = 1'b1;
                while (request_q.size() > k + 1)
                    void'(request_q.pop_back());
            end
            1:
            begin
                request_q[k].data_byte = random_delimiter();
            end
            2:
            begin
                // Empty method, URL or version.
                case ($urandom_range(0, 2))
                    0: request_q.insert(0, item_t'({CH_SPACE, 1'b0}));
                    1: request_q.insert(url_pos, item_t'({CH_SPACE, 1'b0}));
                    default: request_q.insert(ver_pos, item_t'({CH_CR, 1'b0}));
                endcase
            end
            3:
            begin
                // The line feed after the empty line is not the final byte.
                request_q[request_q.size() - 1].last_byte = 1'b0;
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default:
            begin
                request_q[request_q.size() - 1].data_byte = random_other(CH_LF);
            end
        endcase
    endtask

    // Random bytes, rich in delimiters.
    task automatic build_noise();
        int n;
        request_q.delete();
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                push_byte(random_delimiter(), i == n - 1);
            else
                push_byte(8'($urandom_range(0, 255)), i == n - 1);
        end
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SLOW_SINK:
            begin
                send_idle_pct = 25;
                recv_idle_pct = 54;
            end
            IDLE_SLOW_SOURCE:
            begin
                send_idle_pct = 54;
                recv_idle_pct = 25;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one byte, wait for its transfer and record the result it owes.
    task automatic send_byte(input item_t it, input bit typed, input result_t typed_res);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= it.data_byte;
        last_byte <= it.last_byte;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        predicted = classify_byte(it.data_byte, it.last_byte);
        classified_due.insert(classified_due.size(), typed ? typed_res : predicted);
    endtask

    task automatic send_request();
        foreach (request_q[i])
            send_byte(request_q[i], PREDICTED, '0);
    endtask

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare every result transfer with the oldest result owed. Sampling
    // at the falling edge sees the values that the next rising edge takes.
    always @(negedge clk)
    begin : result_check
        result_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (classified_due.size() == 0)
            begin
                $error("result transfer with none outstanding: tag %0d index %0d verdict %0d",
                       field_tag, header_index, verdict);
                fault_count++;
            end
            else
            begin
                due = classified_due.pop_front();
                if (field_tag !== due.field_tag)
                begin
                    $error("field_tag: expected %0d, actual %0d", due.field_tag, field_tag);
                    fault_count++;
                end
                if (header_index !== due.header_index)
                begin
                    $error("header_index: expected %0d, actual %0d",
                           due.header_index, header_index);
                    fault_count++;
                end
                if (verdict !== due.verdict)
                begin
                    $error("verdict: expected %0d, actual %0d", due.verdict, verdict);
                    fault_count++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        result_t    typed_res;
        int         bytes_sent;
        int         pick;
        bit         saturated;
        idle_mode_t mode;
        bytes_sent = 0;
        saturated = 1'b0;
        set_idling(IDLE_SLOW_SINK);

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_rows[i])
        begin
            typed_res.field_tag    = directed_rows[i].field_tag;
            typed_res.header_index = directed_rows[i].header_index;
            typed_res.verdict      = directed_rows[i].verdict;
            send_byte({directed_rows[i].data_byte, directed_rows[i].last_byte},
                      directed_rows[i].typed, typed_res);
        end

        // Random requests, mostly well formed, through the three idling modes.
        while (bytes_sent < RANDOM_BYTES)
        begin
            mode = idle_mode_t'((bytes_sent * 3) / RANDOM_BYTES);
            set_idling(mode);
            if (mode == IDLE_NONE && !saturated)
            begin
                // Enough header lines to hold the count at its ceiling.
                build_wellformed(SATURATING_LINES, 1);
                send_request();
                saturated = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                build_wellformed($urandom_range(0, 4), 12);
            else if (pick < 90)
                build_broken();
            else
                build_noise();
            send_request();
            bytes_sent += request_q.size();
        end
        in_valid <= 1'b0;

        while (classified_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fault_count == 0)
            $display("** http_request_header_parser: PASSED **");
        else
            $display("** http_request_header_parser: FAILED **");
        $finish;
    end

    // Watchdog against a stalled handshake.
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("** http_request_header_parser: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

/* http_request_header_parser.f */
+incdir+rtl
rtl/hrp_pkg.sv
rtl/hrp_input_stage.sv
rtl/hrp_parse_core.sv
rtl/hrp_output_stage.sv
rtl/http_request_header_parser.sv
rtl/hrp_checker.sv
tb/testbench.sv
